// File: rtl/core/mbcs_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the multi-bulk command scanner: event codes, marker
// characters, register indexes and parameter defaults. No dependencies.
package mbcs_pkg;

    localparam int COUNT_BITS_DEF  = 20;
    localparam int LENGTH_BITS_DEF = 32;
    localparam int SIZE_BITS_DEF   = 48;

    // result event codes
    localparam int EVENT_BITS = 3;
    localparam logic [EVENT_BITS-1:0] EV_FRAME = 3'd0;
    localparam logic [EVENT_BITS-1:0] EV_BYTE  = 3'd1;
    localparam logic [EVENT_BITS-1:0] EV_WORD  = 3'd2;
    localparam logic [EVENT_BITS-1:0] EV_DONE  = 3'd3;
    localparam logic [EVENT_BITS-1:0] EV_BAD   = 3'd4;

    // stream characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_ELEMENTS   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_WORD_BYTES = 1'b1;

    // reset value of the bulk length limit: 2**29, all ones if it does not fit
    localparam int              WORD_LIMIT_RST_LOG2 = 29;
    localparam longint unsigned WORD_LIMIT_RST      = 64'd536870912;

endpackage

// File: rtl/core/multibulk_command_scanner.sv
`timescale 1ns / 1ps
// Multi-bulk command scanner, top level.
// Depends on mbcs_pkg, mbcs_cfg_regs, mbcs_in_reg and mbcs_parser.
//
// Usage:
//   s_axis carries the raw command stream, one byte per transaction in tdata.
//   m_axis returns one result per byte: tuser is the event (framing, payload
//   byte, word complete, command complete, not a command), tdata the payload
//   byte, word index, offset, word length, element count and command bytes.
//   The cfg channel writes the element count limit (index 0) and the bulk
//   length limit (index 1); write only while no byte is in flight.
// Timing:
//   A byte accepted into the input register moves on into the result register,
//   where its result shows. One byte is taken every cycle while m_axis does not
//   stall; the parse state update, a multiply by ten and a compare, is
//   combinational logic between those two registers.
// Reset (i_rst_n low, synchronous) empties both registers, restores the
// limits and puts the parser back to waiting for a star.
// When m_axis stalls, the result holds and one more byte is held in the input
// register; s_axis_tready then drops until the result is taken.
module multibulk_command_scanner #(
    parameter int COUNT_BITS  = mbcs_pkg::COUNT_BITS_DEF,
    parameter int LENGTH_BITS = mbcs_pkg::LENGTH_BITS_DEF,
    parameter int SIZE_BITS   = mbcs_pkg::SIZE_BITS_DEF,
    parameter int CFG_BITS    = (COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS,
    parameter int TDATA_BITS  = ((8 + 2 * COUNT_BITS + 2 * LENGTH_BITS + SIZE_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // data_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // payload_byte, word_index, word_offset, word_length, element_count,
    // command_bytes, zero fill
    output logic [TDATA_BITS-1:0]             m_axis_tdata,
    output logic [mbcs_pkg::EVENT_BITS-1:0]   m_axis_tuser,   // event_res
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mbcs_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]               i_cfg_data
);
    import mbcs_pkg::*;

    logic [COUNT_BITS-1:0]  max_elements;
    logic [LENGTH_BITS-1:0] max_word_bytes;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             in_data;

    mbcs_cfg_regs #(
        .COUNT_BITS  (COUNT_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .CFG_BITS    (CFG_BITS)
    ) u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_max_elements   (max_elements),
        .o_max_word_bytes (max_word_bytes)
    );

    mbcs_in_reg u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .o_valid      (in_valid),
        .i_down_ready (in_ready),
        .o_data       (in_data)
    );

    mbcs_parser #(
        .COUNT_BITS  (COUNT_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .SIZE_BITS   (SIZE_BITS),
        .TDATA_BITS  (TDATA_BITS)
    ) u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_data           (in_data),
        .i_max_elements   (max_elements),
        .i_max_word_bytes (max_word_bytes),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_event          (m_axis_tuser),
        .o_tdata          (m_axis_tdata)
    );

endmodule

// File: rtl/core/mbcs_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration registers of the scanner: element count and bulk length limits.
// Depends on mbcs_pkg.
module mbcs_cfg_regs #(
    parameter int COUNT_BITS  = mbcs_pkg::COUNT_BITS_DEF,
    parameter int LENGTH_BITS = mbcs_pkg::LENGTH_BITS_DEF,
    parameter int CFG_BITS    = (COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mbcs_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]               i_cfg_data,
    output logic [COUNT_BITS-1:0]             o_max_elements,
    output logic [LENGTH_BITS-1:0]            o_max_word_bytes
);
    import mbcs_pkg::*;

    localparam logic [LENGTH_BITS-1:0] WORD_RST =
        (LENGTH_BITS > WORD_LIMIT_RST_LOG2) ? LENGTH_BITS'(WORD_LIMIT_RST) : '1;

    logic [COUNT_BITS-1:0]  r_max_elements;
    logic [LENGTH_BITS-1:0] r_max_word_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_elements   <= '1;
            r_max_word_bytes <= WORD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAX_ELEMENTS:   r_max_elements   <= i_cfg_data[COUNT_BITS-1:0];
                REG_MAX_WORD_BYTES: r_max_word_bytes <= i_cfg_data[LENGTH_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_max_elements   = r_max_elements;
    assign o_max_word_bytes = r_max_word_bytes;

endmodule

// File: rtl/core/mbcs_in_reg.sv
`timescale 1ns / 1ps
// Input register of the scanner: holds one accepted byte for the parser.
// Depends on nothing but the clock and reset.
module mbcs_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    output logic       o_valid,
    input  logic       i_down_ready,
    output logic [7:0] o_data
);
    logic       r_valid;
    logic [7:0] r_data;

    // take a new byte when empty or when the held one leaves in the same cycle
    assign o_ready = !r_valid || i_down_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_down_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/core/mbcs_parser.sv
`timescale 1ns / 1ps
// Parse state machine and result register: one byte in, one event out.
// Depends on mbcs_pkg.
module mbcs_parser #(
    parameter int COUNT_BITS  = mbcs_pkg::COUNT_BITS_DEF,
    parameter int LENGTH_BITS = mbcs_pkg::LENGTH_BITS_DEF,
    parameter int SIZE_BITS   = mbcs_pkg::SIZE_BITS_DEF,
    parameter int TDATA_BITS  = ((8 + 2 * COUNT_BITS + 2 * LENGTH_BITS + SIZE_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_data,
    input  logic [COUNT_BITS-1:0]           i_max_elements,
    input  logic [LENGTH_BITS-1:0]          i_max_word_bytes,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [mbcs_pkg::EVENT_BITS-1:0] o_event,
    output logic [TDATA_BITS-1:0]           o_tdata
);
    import mbcs_pkg::*;

    localparam int ACC_BITS  = (COUNT_BITS > LENGTH_BITS) ? COUNT_BITS : LENGTH_BITS;
    localparam int PROD_BITS = ACC_BITS + 4;

    localparam logic [3:0] PH_WAIT     = 4'd0;
    localparam logic [3:0] PH_COUNT    = 4'd1;
    localparam logic [3:0] PH_COUNT_LF = 4'd2;
    localparam logic [3:0] PH_DOLLAR   = 4'd3;
    localparam logic [3:0] PH_LEN      = 4'd4;
    localparam logic [3:0] PH_LEN_LF   = 4'd5;
    localparam logic [3:0] PH_PAYLOAD  = 4'd6;
    localparam logic [3:0] PH_PAY_CR   = 4'd7;
    localparam logic [3:0] PH_PAY_LF   = 4'd8;

    // parse state
    logic [3:0]             r_phase, n_phase;
    logic [ACC_BITS-1:0]    r_acc, n_acc;
    logic                   r_seen, n_seen;
    logic [COUNT_BITS-1:0]  r_total, n_total;
    logic [COUNT_BITS-1:0]  r_pos, n_pos;
    logic [LENGTH_BITS-1:0] r_left, n_left;
    logic [LENGTH_BITS-1:0] r_wsize, n_wsize;
    logic [SIZE_BITS-1:0]   r_cnt, n_cnt;

    // result register
    logic                   r_out_valid;
    logic [EVENT_BITS-1:0]  r_ev, n_ev;
    logic [7:0]             r_pbyte, n_pbyte;
    logic [COUNT_BITS-1:0]  r_windex;
    logic [LENGTH_BITS-1:0] r_offset, n_offset;
    logic [LENGTH_BITS-1:0] r_wlen;
    logic [COUNT_BITS-1:0]  r_ecount;
    logic [SIZE_BITS-1:0]   r_cbytes;

    logic                   fire;
    logic                   wait_ph;
    logic [ACC_BITS-1:0]    c_acc;
    logic                   c_seen;
    logic [COUNT_BITS-1:0]  c_total;
    logic [COUNT_BITS-1:0]  c_pos;
    logic [LENGTH_BITS-1:0] c_left;
    logic [LENGTH_BITS-1:0] c_wsize;
    logic [SIZE_BITS-1:0]   c_cnt;
    logic                   is_digit;
    logic [3:0]             digit_val;
    logic [ACC_BITS-1:0]    limit;
    logic [PROD_BITS-1:0]   acc_ext;
    logic [PROD_BITS-1:0]   prod;
    logic                   over;
    logic                   last_elem;
    logic [3:0]             num_next;

    assign o_ready = !r_out_valid || i_ready;
    assign fire    = i_valid && o_ready;

    // a new command starts from cleared counters
    assign wait_ph = (r_phase == PH_WAIT);
    assign c_acc   = wait_ph ? '0 : r_acc;
    assign c_seen  = wait_ph ? 1'b0 : r_seen;
    assign c_total = wait_ph ? '0 : r_total;
    assign c_pos   = wait_ph ? '0 : r_pos;
    assign c_left  = wait_ph ? '0 : r_left;
    assign c_wsize = wait_ph ? '0 : r_wsize;
    assign c_cnt   = wait_ph ? '0 : r_cnt;

    assign is_digit  = (i_data >= CH_ZERO) && (i_data <= CH_NINE);
    assign digit_val = 4'(i_data - CH_ZERO);
    assign limit     = (r_phase == PH_COUNT) ? ACC_BITS'(i_max_elements)
                                             : ACC_BITS'(i_max_word_bytes);
    assign acc_ext   = PROD_BITS'(c_acc);
    assign prod      = (acc_ext << 3) + (acc_ext << 1) + PROD_BITS'(digit_val);
    assign over      = prod > PROD_BITS'(limit);
    assign last_elem = ({1'b0, c_pos} + (COUNT_BITS + 1)'(1)) >= {1'b0, c_total};
    assign num_next  = (r_phase == PH_COUNT) ? PH_COUNT_LF : PH_LEN_LF;

    always_comb begin
        n_phase  = r_phase;
        n_acc    = c_acc;
        n_seen   = c_seen;
        n_total  = c_total;
        n_pos    = c_pos;
        n_left   = c_left;
        n_wsize  = c_wsize;
        n_cnt    = (c_cnt == '1) ? c_cnt : c_cnt + SIZE_BITS'(1);
        n_ev     = EV_FRAME;
        n_pbyte  = '0;
        n_offset = '0;
        case (r_phase)
            PH_WAIT: begin
                if (i_data == CH_STAR) begin
                    n_phase = PH_COUNT;
                end else begin
                    n_ev = EV_BAD;
                end
            end
            PH_COUNT, PH_LEN: begin
                if (is_digit) begin
                    if (over) begin
                        n_ev = EV_BAD;
                    end else begin
                        n_acc  = prod[ACC_BITS-1:0];
                        n_seen = 1'b1;
                    end
                end else if (c_seen && i_data == CH_CR) begin
                    n_phase = num_next;
                end else begin
                    n_ev = EV_BAD;
                end
            end
            PH_COUNT_LF: begin
                if (i_data != CH_LF) begin
                    n_ev = EV_BAD;
                end else begin
                    n_total = c_acc[COUNT_BITS-1:0];
                    if (c_acc[COUNT_BITS-1:0] == '0) begin
                        n_ev    = EV_DONE;
                        n_phase = PH_WAIT;
                    end else begin
                        n_phase = PH_DOLLAR;
                    end
                end
            end
            PH_DOLLAR: begin
                if (i_data == CH_DOLLAR) begin
                    n_acc   = '0;
                    n_seen  = 1'b0;
                    n_wsize = '0;
                    n_phase = PH_LEN;
                end else begin
                    n_ev = EV_BAD;
                end
            end
            PH_LEN_LF: begin
                if (i_data != CH_LF) begin
                    n_ev = EV_BAD;
                end else begin
                    n_wsize = c_acc[LENGTH_BITS-1:0];
                    n_left  = c_acc[LENGTH_BITS-1:0];
                    n_phase = (c_acc[LENGTH_BITS-1:0] == '0) ? PH_PAY_CR : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_ev     = EV_BYTE;
                n_pbyte  = i_data;
                n_offset = c_wsize - c_left;
                if (c_left != '0) begin
                    n_left = c_left - LENGTH_BITS'(1);
                end
                if (c_left <= LENGTH_BITS'(1)) begin
                    n_phase = PH_PAY_CR;
                end
            end
            PH_PAY_CR: begin
                if (i_data == CH_CR) begin
                    n_phase = PH_PAY_LF;
                end else begin
                    n_ev = EV_BAD;
                end
            end
            PH_PAY_LF: begin
                if (i_data != CH_LF) begin
                    n_ev = EV_BAD;
                end else if (last_elem) begin
                    n_ev    = EV_DONE;
                    n_phase = PH_WAIT;
                end else begin
                    n_ev = EV_WORD;
                end
            end
            default: begin
                n_ev = EV_BAD;
            end
        endcase
        // advance to the next element, or drop the command
        if (n_ev == EV_WORD) begin
            n_pos   = c_pos + COUNT_BITS'(1);
            n_phase = PH_DOLLAR;
        end
        if (n_ev == EV_BAD) begin
            n_phase = PH_WAIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_acc    <= n_acc;
            r_seen   <= n_seen;
            r_total  <= n_total;
            r_pos    <= n_pos;
            r_left   <= n_left;
            r_wsize  <= n_wsize;
            r_cnt    <= n_cnt;
            r_ev     <= n_ev;
            r_pbyte  <= n_pbyte;
            r_windex <= c_pos;
            r_offset <= n_offset;
            r_wlen   <= n_wsize;
            r_ecount <= n_total;
            r_cbytes <= n_cnt;
        end
    end

    assign o_valid = r_out_valid;
    assign o_event = r_ev;
    assign o_tdata = TDATA_BITS'({r_cbytes, r_ecount, r_wlen, r_offset, r_windex, r_pbyte});

    a_pbyte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_ev != EV_BYTE |-> r_pbyte == '0)
        else $error("payload byte set on a non-payload event");

    a_offset_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_ev == EV_BYTE |-> r_offset < r_wlen)
        else $error("payload offset beyond declared word length");

    a_bad_to_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (n_ev == EV_BAD || n_ev == EV_DONE) |=> r_phase == PH_WAIT)
        else $error("parser did not return to waiting after end of command");

    a_bytes_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_cbytes != '0)
        else $error("result carries a zero command byte count");

endmodule
